>>> sv/dense_gemv_engine_assert.svh
// Assertion macros used by the checker file.
`ifndef DENSE_GEMV_ENGINE_ASSERT_SVH
`define DENSE_GEMV_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define DGE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define DGE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/dge_pkg.sv
// ----------------------------------------------------------------------------
// dge_pkg
// Shared sizes, codes and helper functions of the matrix-vector engine.
// ----------------------------------------------------------------------------
package dge_pkg;

    localparam int MAX_DIM    = 16;
    localparam int DIM_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W      = $clog2(MAX_DIM + 1);
    localparam int ADDR_W     = 2 * DIM_W;
    localparam int WORD_W     = 32;

    localparam logic [1:0] MODE_WR_A    = 2'd0;
    localparam logic [1:0] MODE_WR_X    = 2'd1;
    localparam logic [1:0] MODE_WR_Y    = 2'd2;
    localparam logic [1:0] MODE_COMPUTE = 2'd3;

    localparam logic [2:0] CFG_ALPHA     = 3'd0;
    localparam logic [2:0] CFG_BETA      = 3'd1;
    localparam logic [2:0] CFG_TRANSPOSE = 3'd2;
    localparam logic [2:0] CFG_NUM_ROWS  = 3'd3;
    localparam logic [2:0] CFG_NUM_COLS  = 3'd4;

    // Clips a dimension register: zero acts as one, above MAX_DIM acts as MAX_DIM.
    function automatic logic [CNT_W-1:0] dim_clip(input logic [6:0] n);
        logic [CNT_W-1:0] r;
        if (n == 7'd0) begin
            r = CNT_W'(1);
        end else if (32'(n) > MAX_DIM) begin
            r = CNT_W'(MAX_DIM);
        end else begin
            r = CNT_W'(n);
        end
        return r;
    endfunction

endpackage

>>> sv/dge_cell.sv
// ----------------------------------------------------------------------------
// dge_cell
// One word of a rotating vector ring: loads its own entry or takes its neighbor.
// ----------------------------------------------------------------------------
module dge_cell (
    input  logic                             i_clk,
    input  logic                             i_shift,
    input  logic signed [dge_pkg::WORD_W-1:0] i_shift_data,
    input  logic                             i_load,
    input  logic signed [dge_pkg::WORD_W-1:0] i_load_data,
    output logic signed [dge_pkg::WORD_W-1:0] o_data
);

    logic signed [dge_pkg::WORD_W-1:0] r_word;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_word <= i_shift_data;
        end else if (i_load) begin
            r_word <= i_load_data;
        end
    end

    assign o_data = r_word;

endmodule

>>> sv/dense_gemv_engine.sv
// ----------------------------------------------------------------------------
// dense_gemv_engine
// General matrix-vector multiply y = alpha*op(A)*x + beta*y in Q16.16.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): each transaction carries a mode.
// Modes write one matrix entry, one x element or one y element. The compute
// mode forms the new y vector and returns one output transaction per y element
// (o_out_index, o_out_value, o_last), in index order.
// The x and y vectors live in two rings of cells that rotate one place per
// step, so the head cell always shows the element in use; each ring is back
// in its home position when a compute ends. The matrix is a registered memory.
// In a compute, every used row slot walks all MAX_DIM columns through the single
// multiply-accumulate unit, then passes through the drain, alpha, beta, sum and
// emit states for the scaling and the output; slots beyond the used size only
// rotate the y ring.
// The input stall is high for the whole compute; configuration writes
// (i_cfg_valid / o_cfg_ready, always ready) are meant for idle periods only.
// A stalled output holds its transaction and the engine waits for it.
// Reset restores the register defaults and idles the engine; stores keep junk
// until written.
// ----------------------------------------------------------------------------
module dense_gemv_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_mode,
    input  logic [5:0]         i_row,
    input  logic [5:0]         i_col,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [5:0]         o_out_index,
    output logic signed [31:0] o_out_value,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int MD   = dge_pkg::MAX_DIM;
    localparam int DW   = dge_pkg::DIM_W;
    localparam int CW   = dge_pkg::CNT_W;
    localparam int AW   = dge_pkg::ADDR_W;
    localparam int WW   = dge_pkg::WORD_W;
    localparam logic signed [51:0] A_CAP_POS = 52'sd1 <<< 50;
    localparam logic signed [51:0] A_CAP_NEG = -(52'sd1 <<< 50);

    typedef enum logic [3:0] {
        S_IDLE, S_ROW, S_MAC, S_DRAIN, S_ALO, S_AHI, S_BETA, S_SUM, S_EMIT
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic signed [31:0] r_alpha;
    logic signed [31:0] r_beta;
    logic               r_transpose;
    logic [6:0]         r_num_rows;
    logic [6:0]         r_num_cols;

    // Sequencing.
    logic [CW-1:0] r_ny;
    logic [CW-1:0] r_nx;
    logic          r_tr;
    logic [DW-1:0] r_i;
    logic [DW-1:0] r_k;
    logic          r_drain;

    // Datapath.
    logic signed [WW-1:0] r_mem [MD*MD];
    logic signed [WW-1:0] r_a;
    logic signed [WW-1:0] r_xk;
    logic                 r_v1;
    logic                 r_v2;
    logic signed [63:0]   r_prod;
    logic signed [63:0]   r_acc;
    logic signed [64:0]   r_plo;
    logic signed [63:0]   r_phi;
    logic signed [63:0]   r_pb;
    logic signed [51:0]   r_a_term;

    logic in_acc;
    logic cfg_acc;
    logic out_free;
    logic x_shift;
    logic y_shift;
    logic signed [WW-1:0] y_tail;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic signed [WW-1:0] x_q [MD];
    logic signed [WW-1:0] y_q [MD];
    logic signed [96:0] a_full;
    logic signed [96:0] a_q;
    logic signed [52:0] sum;
    logic signed [WW-1:0] sat;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = !o_out_valid || !i_out_stall;

    // Vector rings: cell 0 is the head, each cell takes its upper neighbor.
    assign x_shift = (r_state == S_MAC);
    assign y_shift = ((r_state == S_ROW) && ({1'b0, r_i} >= r_ny))
                  || ((r_state == S_EMIT) && out_free);
    assign y_tail  = (r_state == S_EMIT) ? sat : y_q[0];

    for (genvar j = 0; j < MD; j++) begin : g_ring
        logic ld_x;
        logic ld_y;
        assign ld_x = in_acc && (i_mode == dge_pkg::MODE_WR_X) && (32'(i_row) == j);
        assign ld_y = in_acc && (i_mode == dge_pkg::MODE_WR_Y) && (32'(i_row) == j);
        dge_cell u_x (
            .i_clk       (i_clk),
            .i_shift     (x_shift),
            .i_shift_data((j == MD - 1) ? x_q[0] : x_q[(j + 1) % MD]),
            .i_load      (ld_x),
            .i_load_data (i_value),
            .o_data      (x_q[j])
        );
        dge_cell u_y (
            .i_clk       (i_clk),
            .i_shift     (y_shift),
            .i_shift_data((j == MD - 1) ? y_tail : y_q[(j + 1) % MD]),
            .i_load      (ld_y),
            .i_load_data (i_value),
            .o_data      (y_q[j])
        );
    end

    // Matrix memory: entry A[r][c] at r*MAX_DIM+c.
    assign rd_addr = r_tr ? {r_k, r_i} : {r_i, r_k};
    assign wr_addr = {i_row[DW-1:0], i_col[DW-1:0]};

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_mode == dge_pkg::MODE_WR_A)
                && (32'(i_row) < MD) && (32'(i_col) < MD)) begin
            r_mem[wr_addr] <= i_value;
        end
        r_a <= r_mem[rd_addr];
    end

    // Scaling and saturation.
    assign a_full = (97'(r_phi) <<< 32) + 97'(r_plo);
    assign a_q    = a_full >>> 16;
    assign sum    = 53'(r_a_term) + 53'(r_pb >>> 16);

    always_comb begin
        if (sum > 53'sd2147483647) begin
            sat = 32'sh7FFFFFFF;
        end else if (sum < -53'sd2147483648) begin
            sat = 32'sh80000000;
        end else begin
            sat = WW'(sum);
        end
    end

    // Multiply-accumulate pipeline and scaling products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_v1 <= (r_state == S_MAC) && ({1'b0, r_k} < r_nx);
            r_v2 <= r_v1;
            if ((r_state == S_ROW) && ({1'b0, r_i} < r_ny)) begin
                r_acc <= '0;
            end else if (r_v2) begin
                r_acc <= r_acc + (r_prod >>> 16);
            end
        end
        r_xk   <= x_q[0];
        r_prod <= 64'(r_a) * 64'(r_xk);
        if (r_state == S_ALO) begin
            r_plo <= $signed({1'b0, r_acc[31:0]}) * 65'(r_alpha);
        end
        if (r_state == S_AHI) begin
            r_phi <= 64'($signed(r_acc[63:32])) * 64'(r_alpha);
        end
        if (r_state == S_BETA) begin
            r_pb <= 64'(r_beta) * 64'(y_q[0]);
        end
        if (r_state == S_SUM) begin
            if (a_q > 97'(A_CAP_POS)) begin
                r_a_term <= A_CAP_POS;
            end else if (a_q < 97'(A_CAP_NEG)) begin
                r_a_term <= A_CAP_NEG;
            end else begin
                r_a_term <= 52'(a_q);
            end
        end
    end

    // Control: state, counters, configuration and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_alpha     <= 32'sd65536;
            r_beta      <= '0;
            r_transpose <= 1'b0;
            r_num_rows  <= 7'd16;
            r_num_cols  <= 7'd16;
            r_ny        <= '0;
            r_nx        <= '0;
            r_tr        <= 1'b0;
            r_i         <= '0;
            r_k         <= '0;
            r_drain     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    dge_pkg::CFG_ALPHA:     r_alpha     <= i_cfg_data;
                    dge_pkg::CFG_BETA:      r_beta      <= i_cfg_data;
                    dge_pkg::CFG_TRANSPOSE: r_transpose <= i_cfg_data[0];
                    dge_pkg::CFG_NUM_ROWS:  r_num_rows  <= i_cfg_data[6:0];
                    dge_pkg::CFG_NUM_COLS:  r_num_cols  <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_mode == dge_pkg::MODE_COMPUTE)) begin
                        r_tr    <= r_transpose;
                        r_ny    <= r_transpose ? dge_pkg::dim_clip(r_num_cols)
                                               : dge_pkg::dim_clip(r_num_rows);
                        r_nx    <= r_transpose ? dge_pkg::dim_clip(r_num_rows)
                                               : dge_pkg::dim_clip(r_num_cols);
                        r_i     <= '0;
                        r_state <= S_ROW;
                    end
                end
                S_ROW: begin
                    if ({1'b0, r_i} < r_ny) begin
                        r_k     <= '0;
                        r_state <= S_MAC;
                    end else if (32'(r_i) == MD - 1) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_MAC: begin
                    r_k <= r_k + 1'b1;
                    if (32'(r_k) == MD - 1) begin
                        r_drain <= 1'b0;
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_drain <= 1'b1;
                    if (r_drain) begin
                        r_state <= S_ALO;
                    end
                end
                S_ALO:  r_state <= S_AHI;
                S_AHI:  r_state <= S_BETA;
                S_BETA: r_state <= S_SUM;
                S_SUM:  r_state <= S_EMIT;
                S_EMIT: begin
                    if (out_free) begin
                        o_out_valid <= 1'b1;
                        o_out_index <= 6'(r_i);
                        o_out_value <= sat;
                        o_last      <= ({1'b0, r_i} + 1'b1 == r_ny);
                        if (32'(r_i) == MD - 1) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_ROW;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> sv/dge_checker.sv
// ----------------------------------------------------------------------------
// dge_checker
// Port-level checks of the matrix-vector engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "dense_gemv_engine_assert.svh"

module dge_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [1:0]         i_mode,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [5:0]         o_out_index,
    input logic signed [31:0] o_out_value,
    input logic               o_last
);

    // A stalled output transaction stays and keeps its payload.
    `DGE_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "output dropped")
    `DGE_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_value) && $stable(o_out_index) && $stable(o_last), "output payload changed")
    // A compute keeps the input closed until it has run.
    `DGE_ASSERT_NEXT(a_busy, i_in_valid && !o_in_stall && i_mode == dge_pkg::MODE_COMPUTE, o_in_stall, "input open during compute")
    // More elements follow a non-final one, so the engine stays busy.
    `DGE_ASSERT_NEXT(a_more, o_out_valid && !i_out_stall && !o_last, o_in_stall, "compute ended early")

endmodule

bind dense_gemv_engine dge_checker u_dge_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_mode      (i_mode),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_index (o_out_index),
    .o_out_value (o_out_value),
    .o_last      (o_last)
);

>>> test/tb_dense_gemv_engine.sv
// ----------------------------------------------------------------------------
// tb_dense_gemv_engine
// Self-checking testbench of the Q16.16 matrix-vector multiply engine.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the matrix, x and y stores and of the
// configuration, and predicts every output element of a compute at the moment
// that the compute transaction is accepted. A monitor process compares each
// accepted output transaction with the oldest prediction. Stimulus runs as a
// series of named tests: a full store load, a directed test of corner cases,
// and random phases with different amounts of sender idling and receiver
// stalling.
// ----------------------------------------------------------------------------
module tb_dense_gemv_engine;
    import dge_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam longint CAP50   = longint'(1) <<< 50;

    typedef struct {
        logic [5:0]         idx;
        logic signed [31:0] val;
        logic               last;
    } y_elem_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_mode = MODE_WR_A;
    logic [5:0]         i_row = '0;
    logic [5:0]         i_col = '0;
    logic signed [31:0] i_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [5:0]         o_out_index;
    logic signed [31:0] o_out_value;
    logic               o_last;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = CFG_ALPHA;
    logic [31:0]        i_cfg_data = '0;

    dense_gemv_engine i_dut (.*);

    // Shadow state of the engine.
    longint  mat_mem [MAX_DIM*MAX_DIM];
    longint  x_vec [MAX_DIM];
    longint  y_vec [MAX_DIM];
    longint  alpha_q = 65536;
    longint  beta_q = 0;
    bit      transp = 1'b0;
    int      rows_reg = 16;
    int      cols_reg = 16;

    y_elem_t expected_y[$];
    int      err_count = 0;
    int      cycles = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The whole run is bounded so that a hung handshake cannot stall it.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver backpressure follows the current phase.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycles, msg);
        err_count++;
    endtask

    // Every accepted output transaction must match the oldest prediction.
    always @(posedge i_clk) begin
        y_elem_t e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_y.size() == 0) begin
                report_mismatch($sformatf("unexpected output index %0d", o_out_index));
            end else begin
                e = expected_y.pop_front();
                if (o_out_index !== e.idx || o_out_value !== e.val || o_last !== e.last)
                    report_mismatch($sformatf("got idx %0d val %h last %b, want %0d %h %b",
                        o_out_index, o_out_value, o_last, e.idx, e.val, e.last));
            end
        end
    end

    function automatic longint fx_mul(input longint a, input longint b);
        return (a * b) >>> 16;
    endfunction

    // floor(alpha*dot/2^16), clamped to +-2^50.
    function automatic longint scale_by_alpha(input longint a, input longint dot);
        logic signed [127:0] p;
        p = (128'(signed'(a)) * 128'(signed'(dot))) >>> 16;
        if (p > 128'(CAP50))
            return CAP50;
        if (p < -128'(CAP50))
            return -CAP50;
        return longint'(p);
    endfunction

    function automatic longint clamp_word(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic int clip_dim(input int n);
        if (n == 0)
            return 1;
        return (n > MAX_DIM) ? MAX_DIM : n;
    endfunction

    // Forms the new y vector, writes it back and queues every element.
    task automatic predict_gemv();
        int      ny, nx;
        longint  dot, res, a;
        y_elem_t e;
        ny = transp ? clip_dim(cols_reg) : clip_dim(rows_reg);
        nx = transp ? clip_dim(rows_reg) : clip_dim(cols_reg);
        for (int i = 0; i < ny; i++) begin
            dot = 0;
            for (int k = 0; k < nx; k++) begin
                a = transp ? mat_mem[k*MAX_DIM+i] : mat_mem[i*MAX_DIM+k];
                dot += fx_mul(a, x_vec[k]);
            end
            res = clamp_word(scale_by_alpha(alpha_q, dot) + fx_mul(beta_q, y_vec[i]));
            y_vec[i] = res;
            e.idx = 6'(i);
            e.val = 32'(res);
            e.last = (i == ny - 1);
            expected_y.push_back(e);
        end
    endtask

    // Sends one transaction; valid stays high for a back-to-back follower.
    task automatic send_item(input logic [1:0] mode, input logic [5:0] row,
                             input logic [5:0] col, input logic signed [31:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_row <= row;
        i_col <= col;
        i_value <= value;
        do @(posedge i_clk); while (o_in_stall);
        case (mode)
            MODE_WR_A: if (row < MAX_DIM && col < MAX_DIM) mat_mem[row*MAX_DIM+col] = value;
            MODE_WR_X: if (row < MAX_DIM) x_vec[row] = value;
            MODE_WR_Y: if (row < MAX_DIM) y_vec[row] = value;
            default:   predict_gemv();
        endcase
    endtask

    // Holds the sender until every predicted element has come out.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_y.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ALPHA:     alpha_q = longint'(signed'(data));
            CFG_BETA:      beta_q = longint'(signed'(data));
            CFG_TRANSPOSE: transp = data[0];
            CFG_NUM_ROWS:  rows_reg = int'(data[6:0]);
            CFG_NUM_COLS:  cols_reg = int'(data[6:0]);
            default: ;
        endcase
    endtask

    // Mostly values of moderate size so that results are not all saturated.
    function automatic logic [31:0] rand_word();
        if ($urandom_range(3) == 0)
            return $urandom;
        return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endfunction

    // Every store entry is written before any compute reads it.
    task automatic test_load_stores();
        for (int r = 0; r < MAX_DIM; r++)
            for (int c = 0; c < MAX_DIM; c++)
                send_item(MODE_WR_A, 6'(r), 6'(c), rand_word());
        for (int i = 0; i < MAX_DIM; i++) begin
            send_item(MODE_WR_X, 6'(i), 6'($urandom), rand_word());
            send_item(MODE_WR_Y, 6'(i), 6'($urandom), rand_word());
        end
    endtask

    task automatic test_corners();
        // A compute at reset settings: full size, alpha one, beta zero.
        send_item(MODE_COMPUTE, 6'd0, 6'd0, 32'sd0);
        cfg_write(CFG_NUM_ROWS, 32'd1);
        cfg_write(CFG_NUM_COLS, 32'd1);
        // Positive and negative saturation of the output word.
        send_item(MODE_WR_A, 6'd0, 6'd0, 32'sh7FFFFFFF);
        send_item(MODE_WR_X, 6'd0, 6'd0, 32'sh7FFFFFFF);
        send_item(MODE_COMPUTE, 6'd63, 6'd63, 32'sh7FFFFFFF);
        send_item(MODE_WR_X, 6'd0, 6'd0, 32'sh80000000);
        send_item(MODE_COMPUTE, 6'd0, 6'd0, 32'sh80000000);
        send_item(MODE_WR_A, 6'd0, 6'd0, 32'sh80000000);
        send_item(MODE_COMPUTE, 6'd0, 6'd0, 32'sd0);
        // Extreme scale factors, with the alpha clamp in play.
        cfg_write(CFG_ALPHA, 32'h80000000);
        cfg_write(CFG_BETA, 32'h7FFFFFFF);
        send_item(MODE_WR_Y, 6'd0, 6'd0, 32'sh80000000);
        send_item(MODE_COMPUTE, 6'd0, 6'd0, 32'sd0);
        cfg_write(CFG_ALPHA, 32'h7FFFFFFF);
        cfg_write(CFG_BETA, 32'h80000000);
        send_item(MODE_COMPUTE, 6'd0, 6'd0, 32'sd0);
        // Writes outside the stores are dropped.
        send_item(MODE_WR_A, 6'd63, 6'd63, 32'sh12345678);
        send_item(MODE_WR_A, 6'd3, 6'd40, 32'sh12345678);
        send_item(MODE_WR_X, 6'd63, 6'd0, 32'sh0BADBEEF);
        send_item(MODE_WR_Y, 6'd16, 6'd0, 32'sh0BADBEEF);
        cfg_write(CFG_ALPHA, 32'h00010000);
        cfg_write(CFG_BETA, 32'hFFFF8000);
        // Transposed, non-square shape.
        cfg_write(CFG_TRANSPOSE, 32'd1);
        cfg_write(CFG_NUM_ROWS, 32'd3);
        cfg_write(CFG_NUM_COLS, 32'd5);
        send_item(MODE_COMPUTE, 6'd0, 6'd0, 32'sd0);
        // A zero size acts as one and an oversize acts as the full size.
        cfg_write(CFG_NUM_ROWS, 32'd0);
        cfg_write(CFG_NUM_COLS, 32'd127);
        send_item(MODE_COMPUTE, 6'd0, 6'd0, 32'sd0);
        cfg_write(CFG_TRANSPOSE, 32'd0);
        cfg_write(CFG_NUM_ROWS, 32'd17);
        cfg_write(CFG_NUM_COLS, 32'd64);
        send_item(MODE_COMPUTE, 6'd0, 6'd0, 32'sd0);
    endtask

    task automatic test_random_phase(input int n_items, input int idle, input int stall);
        int r;
        cfg_write(CFG_ALPHA, rand_word());
        cfg_write(CFG_BETA, rand_word());
        cfg_write(CFG_TRANSPOSE, $urandom);
        // Mostly small sizes keep the computes short.
        cfg_write(CFG_NUM_ROWS, ($urandom_range(4) == 0) ? $urandom_range(127)
                                                         : $urandom_range(1, 6));
        cfg_write(CFG_NUM_COLS, ($urandom_range(4) == 0) ? $urandom_range(127)
                                                         : $urandom_range(1, 6));
        send_idle_pct = idle;
        stall_pct = stall;
        for (int n = 0; n < n_items; n++) begin
            r = $urandom_range(99);
            if (n == n_items / 2)
                drain();
            if (r < 15)
                send_item(MODE_COMPUTE, 6'($urandom), 6'($urandom), 32'($urandom));
            else if (r < 90)
                send_item(2'($urandom_range(2)), 6'($urandom_range(MAX_DIM - 1)),
                          6'($urandom_range(MAX_DIM - 1)), rand_word());
            else
                send_item(2'($urandom_range(2)), 6'($urandom), 6'($urandom), $urandom);
        end
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_load_stores();
        test_corners();
        test_random_phase(16, 0, 0);
        test_random_phase(16, 71, 0);
        test_random_phase(16, 0, 71);
        test_random_phase(16, 37, 37);
        test_random_phase(12, 0, 0);
        i_in_valid <= 1'b0;
        while (expected_y.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
